[rtl/i2cms_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// Shared types and codes of the I2C master transaction sequencer.
// Used by the ring, the transmit FIFO and the top level; depends on nothing.

package i2cms_pkg;

    localparam logic [3:0] CMD_ENQ_RD     = 4'd0;
    localparam logic [3:0] CMD_ENQ_WR     = 4'd1;
    localparam logic [3:0] CMD_PUSH_TX    = 4'd2;
    localparam logic [3:0] CMD_START_SENT = 4'd3;
    localparam logic [3:0] CMD_ADDR_SENT  = 4'd4;
    localparam logic [3:0] CMD_BYTE_DONE  = 4'd5;
    localparam logic [3:0] CMD_NACK       = 4'd6;
    localparam logic [3:0] CMD_ARB_LOST   = 4'd7;
    localparam logic [3:0] CMD_BUS_ERR    = 4'd8;
    localparam logic [3:0] CMD_BUS_IDLE   = 4'd9;

    localparam logic [1:0] ACK_NONE    = 2'd0;
    localparam logic [1:0] ACK_SET     = 2'd1;
    localparam logic [1:0] ACK_CLR     = 2'd2;
    localparam logic [1:0] ACK_CLR_POS = 2'd3;

    localparam logic [1:0] ST_ACK  = 2'd0;
    localparam logic [1:0] ST_NACK = 2'd1;
    localparam logic [1:0] ST_ERR  = 2'd2;

    typedef struct packed {
        logic [7:0] count;
        logic [6:0] addr;
        logic       is_write;
    } txn_t;

    typedef struct packed {
        logic enq;
        logic retire;
        txn_t entry;
    } ring_req_t;

    typedef struct packed {
        logic       push;
        logic [7:0] push_data;
        logic       reserve;
        logic [7:0] reserve_count;
        logic       send;
    } fifo_req_t;

endpackage

`default_nettype wire

[rtl/i2cms_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.

module i2cms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[rtl/i2cms_ring.sv]
`timescale 1ns / 1ps
`default_nettype none
// Transaction ring: ready bits in flip-flops, entries in a RAM that is read
// ahead at the slot after the current one. Depends on i2cms_pkg and i2cms_ram.

module i2cms_ring #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire i2cms_pkg::ring_req_t  req,
    output logic                       slot_free,
    output logic                       next_ready,
    output i2cms_pkg::txn_t            next_entry
);

    localparam int QW = $clog2(QUEUE_DEPTH);
    localparam logic [QW-1:0] LAST_SLOT = QW'(QUEUE_DEPTH - 1);
    localparam int EW = $bits(i2cms_pkg::txn_t);

    function automatic logic [QW-1:0] inc_slot(input logic [QW-1:0] v);
        return (v == LAST_SLOT) ? '0 : v + 1'b1;
    endfunction

    logic [QUEUE_DEPTH-1:0] ready_reg;
    logic [QW-1:0]          free_reg;
    logic [QW-1:0]          cur_reg;
    logic                   fwd_reg;
    i2cms_pkg::txn_t        fwd_data_reg;
    logic [QW-1:0]          cur_p1;
    logic [QW-1:0]          cur_p2;
    logic [QW-1:0]          raddr;
    logic                   do_write;
    logic [EW-1:0]          rdata;

    assign cur_p1     = inc_slot(cur_reg);
    assign cur_p2     = inc_slot(cur_p1);
    assign slot_free  = !ready_reg[free_reg];
    assign next_ready = ready_reg[cur_p1];
    assign do_write   = req.enq && slot_free;
    assign raddr      = req.retire ? cur_p2 : cur_p1;
    assign next_entry = fwd_reg ? fwd_data_reg : i2cms_pkg::txn_t'(rdata);

    i2cms_ram #(
        .WIDTH(EW),
        .DEPTH(QUEUE_DEPTH)
    ) u_ram (
        .aclk (aclk),
        .we   (do_write),
        .waddr(free_reg),
        .wdata(req.entry),
        .raddr(raddr),
        .rdata(rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ready_reg <= '0;
            free_reg  <= '0;
            cur_reg   <= '0;
            fwd_reg   <= 1'b0;
        end else begin
            if (do_write) begin
                ready_reg[free_reg] <= 1'b1;
                free_reg            <= inc_slot(free_reg);
            end
            if (req.retire) begin
                ready_reg[cur_reg] <= 1'b0;
                cur_reg            <= cur_p1;
            end
            fwd_reg <= do_write && (free_reg == raddr);
        end
    end

    always_ff @(posedge aclk) begin
        fwd_data_reg <= req.entry;
    end

endmodule

`default_nettype wire

[rtl/i2cms_txfifo.sv]
`timescale 1ns / 1ps
`default_nettype none
// Transmit byte FIFO with reservation of bytes for a write and a send pointer
// whose byte is read ahead from the RAM. Depends on i2cms_pkg and i2cms_ram.

module i2cms_txfifo #(
    parameter int TX_FIFO_DEPTH = 64
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire i2cms_pkg::fifo_req_t  req,
    output logic [7:0]                 send_data
);

    localparam int IW = $clog2(TX_FIFO_DEPTH);
    localparam int PW = $clog2(2 * TX_FIFO_DEPTH);
    localparam int CW = (PW > 8) ? PW : 8;
    localparam logic [PW:0]   TWO_D  = (PW + 1)'(2 * TX_FIFO_DEPTH);
    localparam logic [PW:0]   ONE_D  = (PW + 1)'(TX_FIFO_DEPTH);
    localparam logic [PW-1:0] PTR_LAST = PW'(2 * TX_FIFO_DEPTH - 1);
    localparam logic [IW-1:0] IDX_LAST = IW'(TX_FIFO_DEPTH - 1);

    function automatic logic [IW-1:0] to_idx(input logic [PW-1:0] p);
        logic [PW:0] pe;
        logic [PW:0] pd;
        pe = {1'b0, p};
        pd = pe - ONE_D;
        return (pe >= ONE_D) ? pd[IW-1:0] : pe[IW-1:0];
    endfunction

    logic [PW-1:0] wptr_reg;
    logic [PW-1:0] rptr_reg;
    logic [IW-1:0] sptr_reg;
    logic [IW-1:0] sptr_next;
    logic          fwd_reg;
    logic [7:0]    fwd_data_reg;
    logic [PW:0]   fill_w;
    logic [PW-1:0] fill;
    logic          full;
    logic          do_push;
    logic [IW-1:0] waddr;
    logic [CW-1:0] cnt_ext;
    logic [CW-1:0] fill_ext;
    logic [CW-1:0] take_w;
    logic [PW:0]   rsum;
    logic [PW:0]   rwrap;
    logic [7:0]    rdata;

    assign fill_w   = (wptr_reg >= rptr_reg) ? ({1'b0, wptr_reg} - {1'b0, rptr_reg})
                                              : ({1'b0, wptr_reg} + TWO_D - {1'b0, rptr_reg});
    assign fill     = fill_w[PW-1:0];
    assign full     = ({1'b0, fill} == ONE_D);
    assign do_push  = req.push && !full;
    assign waddr    = to_idx(wptr_reg);
    assign cnt_ext  = CW'(req.reserve_count);
    assign fill_ext = CW'(fill);
    assign take_w   = (cnt_ext < fill_ext) ? cnt_ext : fill_ext;
    assign rsum     = {1'b0, rptr_reg} + {1'b0, take_w[PW-1:0]};
    assign rwrap    = (rsum >= TWO_D) ? (rsum - TWO_D) : rsum;

    always_comb begin
        sptr_next = sptr_reg;
        if (req.reserve) begin
            sptr_next = to_idx(rptr_reg);
        end else if (req.send) begin
            sptr_next = (sptr_reg == IDX_LAST) ? '0 : sptr_reg + 1'b1;
        end
    end

    assign send_data = fwd_reg ? fwd_data_reg : rdata;

    i2cms_ram #(
        .WIDTH(8),
        .DEPTH(TX_FIFO_DEPTH)
    ) u_ram (
        .aclk (aclk),
        .we   (do_push),
        .waddr(waddr),
        .wdata(req.push_data),
        .raddr(sptr_next),
        .rdata(rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            sptr_reg <= '0;
            fwd_reg  <= 1'b0;
        end else begin
            if (do_push) begin
                wptr_reg <= (wptr_reg == PTR_LAST) ? '0 : wptr_reg + 1'b1;
            end
            if (req.reserve) begin
                rptr_reg <= rwrap[PW-1:0];
            end
            sptr_reg <= sptr_next;
            fwd_reg  <= do_push && (waddr == sptr_next);
        end
    end

    always_ff @(posedge aclk) begin
        fwd_data_reg <= req.push_data;
    end

endmodule

`default_nettype wire

[rtl/i2c_master_transaction_sequencer.sv]
`timescale 1ns / 1ps
`default_nettype none
// I2C master transaction sequencer, top level: command decode, transaction
// state and the result register. Depends on i2cms_pkg, i2cms_ring, i2cms_txfifo.
//
//   Channel  Ports       Carries
//   input    s_*         one command or bus event per item
//   result   m_*         one set of controller actions per input item
//
// One item is taken every cycle while s_ready is high; its result is registered
// and shows on m_* in the cycle after acceptance. Both RAMs are read every cycle
// at the address the next item will need, with a same-cycle write forwarded, so
// no item waits. s_ready is low only while a result is held and m_ready is low.
// Reset is synchronous; no clearing pass is needed.

module i2c_master_transaction_sequencer #(
    parameter int QUEUE_DEPTH   = 4,
    parameter int TX_FIFO_DEPTH = 64
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [3:0] s_cmd,
    input  wire logic [6:0] s_slave_address,
    input  wire logic [7:0] s_byte_count,
    input  wire logic [7:0] s_data_byte,
    input  wire logic [7:0] s_data_byte_next,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic            m_accepted,
    output logic            m_drive_start,
    output logic            m_drive_stop,
    output logic [1:0]      m_ack_control,
    output logic            m_tx_valid,
    output logic [7:0]      m_tx_byte,
    output logic [1:0]      m_rx_count,
    output logic [7:0]      m_rx_first,
    output logic [7:0]      m_rx_second,
    output logic            m_done_res,
    output logic [1:0]      m_done_status,
    output logic            m_done_is_write
);

    typedef struct packed {
        logic       accepted;
        logic       drive_start;
        logic       drive_stop;
        logic [1:0] ack_control;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic [1:0] rx_count;
        logic [7:0] rx_first;
        logic [7:0] rx_second;
        logic       done_res;
        logic [1:0] done_status;
        logic       done_is_write;
    } res_t;

    logic                  s_fire;
    logic                  m_valid_reg;
    res_t                  res_reg;
    res_t                  res_next;
    logic                  running_reg;
    logic                  running_next;
    logic                  service_pending_reg;
    logic                  service_pending_next;
    logic [1:0]            bus_status_reg;
    logic [1:0]            bus_status_next;
    logic [7:0]            bytes_left_reg;
    logic [7:0]            bytes_left_next;
    i2cms_pkg::txn_t       cur_reg;
    i2cms_pkg::txn_t       cur_next;
    i2cms_pkg::txn_t       in_entry;
    i2cms_pkg::txn_t       start_entry;
    logic                  start_go;
    logic                  send_go;
    i2cms_pkg::ring_req_t  ring_req;
    i2cms_pkg::fifo_req_t  fifo_req;
    logic                  slot_free;
    logic                  next_ready;
    i2cms_pkg::txn_t       next_entry;
    logic [7:0]            send_data;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;

    i2cms_ring #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_ring (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req       (ring_req),
        .slot_free (slot_free),
        .next_ready(next_ready),
        .next_entry(next_entry)
    );

    i2cms_txfifo #(
        .TX_FIFO_DEPTH(TX_FIFO_DEPTH)
    ) u_txfifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (fifo_req),
        .send_data(send_data)
    );

    always_comb begin
        res_next             = '0;
        running_next         = running_reg;
        service_pending_next = service_pending_reg;
        bus_status_next      = bus_status_reg;
        bytes_left_next      = bytes_left_reg;
        cur_next             = cur_reg;
        ring_req             = '0;
        fifo_req             = '0;
        start_go             = 1'b0;
        send_go              = 1'b0;
        in_entry.count       = s_byte_count;
        in_entry.addr        = s_slave_address;
        in_entry.is_write    = (s_cmd == i2cms_pkg::CMD_ENQ_WR);
        start_entry          = in_entry;

        if (s_fire) begin
            unique case (s_cmd)
                i2cms_pkg::CMD_ENQ_RD, i2cms_pkg::CMD_ENQ_WR: begin
                    ring_req.enq   = 1'b1;
                    ring_req.entry = in_entry;
                    if (slot_free) begin
                        res_next.accepted = 1'b1;
                        start_go          = !running_reg;
                    end
                end
                i2cms_pkg::CMD_PUSH_TX: begin
                    fifo_req.push      = 1'b1;
                    fifo_req.push_data = s_data_byte;
                end
                i2cms_pkg::CMD_START_SENT: begin
                    if (running_reg) begin
                        res_next.tx_valid = 1'b1;
                        res_next.tx_byte  = {cur_reg.addr, !cur_reg.is_write};
                    end
                end
                i2cms_pkg::CMD_ADDR_SENT: begin
                    if (running_reg) begin
                        if (cur_reg.is_write) begin
                            send_go = 1'b1;
                        end else if (bytes_left_reg == 8'd1) begin
                            bytes_left_next      = '0;
                            res_next.ack_control = i2cms_pkg::ACK_CLR;
                            res_next.drive_stop  = 1'b1;
                            service_pending_next = 1'b1;
                        end else if (bytes_left_reg == 8'd2) begin
                            res_next.ack_control = i2cms_pkg::ACK_CLR_POS;
                        end
                    end
                end
                i2cms_pkg::CMD_BYTE_DONE: begin
                    if (running_reg) begin
                        if (cur_reg.is_write) begin
                            send_go = 1'b1;
                        end else if (bytes_left_reg == 8'd2) begin
                            res_next.drive_stop  = 1'b1;
                            service_pending_next = 1'b1;
                            res_next.rx_count    = 2'd2;
                            res_next.rx_first    = s_data_byte;
                            res_next.rx_second   = s_data_byte_next;
                            bytes_left_next      = '0;
                        end else begin
                            if (bytes_left_reg == 8'd3) begin
                                res_next.ack_control = i2cms_pkg::ACK_CLR;
                            end
                            res_next.rx_count = 2'd1;
                            res_next.rx_first = s_data_byte;
                            if (bytes_left_reg != 8'd0) begin
                                bytes_left_next = bytes_left_reg - 8'd1;
                            end
                        end
                    end
                end
                i2cms_pkg::CMD_NACK, i2cms_pkg::CMD_ARB_LOST, i2cms_pkg::CMD_BUS_ERR: begin
                    if (running_reg) begin
                        service_pending_next = 1'b1;
                        bus_status_next      = (s_cmd == i2cms_pkg::CMD_NACK) ?
                                               i2cms_pkg::ST_NACK : i2cms_pkg::ST_ERR;
                        res_next.drive_stop  = 1'b1;
                    end
                end
                i2cms_pkg::CMD_BUS_IDLE: begin
                    if (service_pending_reg) begin
                        service_pending_next = 1'b0;
                        if (bus_status_reg == i2cms_pkg::ST_ACK && cur_reg.count == 8'd1 &&
                            !cur_reg.is_write) begin
                            res_next.rx_count = 2'd1;
                            res_next.rx_first = s_data_byte;
                        end
                        res_next.done_res      = 1'b1;
                        res_next.done_status   = bus_status_reg;
                        res_next.done_is_write = cur_reg.is_write;
                        bus_status_next        = i2cms_pkg::ST_ACK;
                        ring_req.retire        = 1'b1;
                        running_next           = 1'b0;
                        start_entry            = next_entry;
                        start_go               = next_ready;
                    end
                end
                default: begin
                end
            endcase
        end

        if (send_go) begin
            if (bytes_left_reg != 8'd0) begin
                res_next.tx_valid = 1'b1;
                res_next.tx_byte  = send_data;
                fifo_req.send     = 1'b1;
                bytes_left_next   = bytes_left_reg - 8'd1;
            end else begin
                res_next.drive_stop  = 1'b1;
                service_pending_next = 1'b1;
            end
        end

        if (start_go) begin
            running_next         = 1'b1;
            bytes_left_next      = start_entry.count;
            cur_next             = start_entry;
            res_next.drive_start = 1'b1;
            if (start_entry.is_write) begin
                fifo_req.reserve       = 1'b1;
                fifo_req.reserve_count = start_entry.count;
            end else begin
                res_next.ack_control = i2cms_pkg::ACK_SET;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg         <= 1'b0;
            running_reg         <= 1'b0;
            service_pending_reg <= 1'b0;
            bus_status_reg      <= i2cms_pkg::ST_ACK;
            bytes_left_reg      <= '0;
        end else begin
            if (s_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            running_reg         <= running_next;
            service_pending_reg <= service_pending_next;
            bus_status_reg      <= bus_status_next;
            bytes_left_reg      <= bytes_left_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        if (s_fire) begin
            res_reg <= res_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_accepted      = res_reg.accepted;
    assign m_drive_start   = res_reg.drive_start;
    assign m_drive_stop    = res_reg.drive_stop;
    assign m_ack_control   = res_reg.ack_control;
    assign m_tx_valid      = res_reg.tx_valid;
    assign m_tx_byte       = res_reg.tx_byte;
    assign m_rx_count      = res_reg.rx_count;
    assign m_rx_first      = res_reg.rx_first;
    assign m_rx_second     = res_reg.rx_second;
    assign m_done_res      = res_reg.done_res;
    assign m_done_status   = res_reg.done_status;
    assign m_done_is_write = res_reg.done_is_write;

    // A pending service only exists while a transaction runs.
    a_pending_needs_running: assert property (@(posedge aclk) disable iff (!aresetn)
        service_pending_reg |-> running_reg)
        else $error("service pending while no transaction runs");

    a_status_needs_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (bus_status_reg != i2cms_pkg::ST_ACK) |-> service_pending_reg)
        else $error("bus status set without pending service");

    a_result_follows_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> m_valid)
        else $error("accepted item produced no result");

    a_done_clears_running: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_cmd == i2cms_pkg::CMD_BUS_IDLE && service_pending_reg && !next_ready)
        |=> !running_reg)
        else $error("transaction still running after retirement with empty ring");

endmodule

`default_nettype wire

[sim/i2c_master_transaction_sequencer_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the I2C master transaction sequencer: a queue-fed driver,
// a monitor and an in-bench model of the transaction ring and transmit FIFO.
// Depends on i2cms_pkg and i2c_master_transaction_sequencer.

module i2c_master_transaction_sequencer_test;

    localparam int RING_SLOTS     = 4;
    localparam int FIFO_BYTES     = 64;
    localparam int ITEM_TOTAL     = 1800;
    localparam int DRAIN_AT       = 900;
    localparam int BACKLOG_AT     = 400;
    localparam int BACKLOG_CYCLES = 300;
    localparam int TAIL_ITEMS     = 150;
    localparam int CYCLE_LIMIT    = 200000;

    typedef enum logic [2:0] {
        PH_START = 3'b001,
        PH_ADDR  = 3'b010,
        PH_DATA  = 3'b100
    } bus_phase_t;

    typedef struct {
        logic [3:0] cmd;
        logic [6:0] addr;
        logic [7:0] count;
        logic [7:0] data;
        logic [7:0] data_next;
    } bus_req_t;

    typedef struct {
        logic       accepted;
        logic       start;
        logic       stop;
        logic [1:0] ack;
        logic       txv;
        logic [7:0] txb;
        logic [1:0] rxn;
        logic [7:0] rx1;
        logic [7:0] rx2;
        logic       done;
        logic [1:0] dst;
        logic       dwr;
    } actions_t;

    typedef struct {
        bus_req_t req;
        actions_t act;
        bit       drain;
    } queued_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [3:0] s_cmd = '0;
    logic [6:0] s_slave_address = '0;
    logic [7:0] s_byte_count = '0;
    logic [7:0] s_data_byte = '0;
    logic [7:0] s_data_byte_next = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic       m_accepted;
    logic       m_drive_start;
    logic       m_drive_stop;
    logic [1:0] m_ack_control;
    logic       m_tx_valid;
    logic [7:0] m_tx_byte;
    logic [1:0] m_rx_count;
    logic [7:0] m_rx_first;
    logic [7:0] m_rx_second;
    logic       m_done_res;
    logic [1:0] m_done_status;
    logic       m_done_is_write;

    i2c_master_transaction_sequencer i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_slave_address (s_slave_address),
        .s_byte_count    (s_byte_count),
        .s_data_byte     (s_data_byte),
        .s_data_byte_next(s_data_byte_next),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_accepted      (m_accepted),
        .m_drive_start   (m_drive_start),
        .m_drive_stop    (m_drive_stop),
        .m_ack_control   (m_ack_control),
        .m_tx_valid      (m_tx_valid),
        .m_tx_byte       (m_tx_byte),
        .m_rx_count      (m_rx_count),
        .m_rx_first      (m_rx_first),
        .m_rx_second     (m_rx_second),
        .m_done_res      (m_done_res),
        .m_done_status   (m_done_status),
        .m_done_is_write (m_done_is_write)
    );

    always #4 aclk = ~aclk;

    // Model of the sequencer state.
    logic       ring_ready [RING_SLOTS];
    logic [7:0] ring_count [RING_SLOTS];
    logic [6:0] ring_addr  [RING_SLOTS];
    logic       ring_wr    [RING_SLOTS];
    logic [1:0] enq_slot;
    logic [1:0] cur_slot;
    logic       busy;
    logic       stop_sent;
    logic [1:0] bus_status;
    logic [7:0] remaining;
    logic [7:0] fifo_mem [FIFO_BYTES];
    logic [6:0] fifo_wr;
    logic [6:0] fifo_rd;
    logic [5:0] send_idx;
    bus_phase_t bus_phase;

    queued_t    pending[$];
    actions_t   expected_actions[$];
    queued_t    offered;
    actions_t   exp_a;
    int         items_sent = 0;
    int         failures = 0;
    int         send_idle = 0;
    int         recv_idle = 0;
    bit         backlog_done = 0;
    int unsigned cycle_count = 0;

    function automatic actions_t launch_txn(input actions_t a);
        logic [6:0] fill7;
        logic [7:0] take;
        busy = 1'b1;
        remaining = ring_count[cur_slot];
        if (ring_wr[cur_slot]) begin
            fill7 = fifo_wr - fifo_rd;
            take = (ring_count[cur_slot] < {1'b0, fill7}) ? ring_count[cur_slot] : {1'b0, fill7};
            send_idx = fifo_rd[5:0];
            fifo_rd = fifo_rd + take[6:0];
        end else begin
            a.ack = i2cms_pkg::ACK_SET;
        end
        a.start = 1'b1;
        return a;
    endfunction

    function automatic actions_t send_next_byte(input actions_t a);
        if (remaining != 0) begin
            a.txv = 1'b1;
            a.txb = fifo_mem[send_idx];
            send_idx = send_idx + 6'd1;
            remaining = remaining - 8'd1;
        end else begin
            a.stop = 1'b1;
            stop_sent = 1'b1;
        end
        return a;
    endfunction

    function automatic actions_t apply_item(input bus_req_t r);
        actions_t a;
        logic [6:0] fill7;
        a = '{default: '0};
        fill7 = fifo_wr - fifo_rd;
        if (r.cmd == i2cms_pkg::CMD_ENQ_RD || r.cmd == i2cms_pkg::CMD_ENQ_WR) begin
            if (!ring_ready[enq_slot]) begin
                ring_ready[enq_slot] = 1'b1;
                ring_count[enq_slot] = r.count;
                ring_addr[enq_slot] = r.addr;
                ring_wr[enq_slot] = (r.cmd == i2cms_pkg::CMD_ENQ_WR);
                enq_slot = enq_slot + 2'd1;
                a.accepted = 1'b1;
                if (!busy) a = launch_txn(a);
            end
        end else if (r.cmd == i2cms_pkg::CMD_PUSH_TX) begin
            if (fill7 < FIFO_BYTES) begin
                fifo_mem[fifo_wr[5:0]] = r.data;
                fifo_wr = fifo_wr + 7'd1;
            end
        end else if (r.cmd >= i2cms_pkg::CMD_START_SENT &&
                     r.cmd <= i2cms_pkg::CMD_BUS_ERR && busy) begin
            case (r.cmd)
                i2cms_pkg::CMD_START_SENT: begin
                    a.txv = 1'b1;
                    a.txb = {ring_addr[cur_slot], ~ring_wr[cur_slot]};
                end
                i2cms_pkg::CMD_ADDR_SENT: begin
                    if (ring_wr[cur_slot]) begin
                        a = send_next_byte(a);
                    end else if (remaining == 8'd1) begin
                        remaining = 8'd0;
                        a.ack = i2cms_pkg::ACK_CLR;
                        a.stop = 1'b1;
                        stop_sent = 1'b1;
                    end else if (remaining == 8'd2) begin
                        a.ack = i2cms_pkg::ACK_CLR_POS;
                    end
                end
                i2cms_pkg::CMD_BYTE_DONE: begin
                    if (ring_wr[cur_slot]) begin
                        a = send_next_byte(a);
                    end else if (remaining == 8'd2) begin
                        a.stop = 1'b1;
                        stop_sent = 1'b1;
                        a.rxn = 2'd2;
                        a.rx1 = r.data;
                        a.rx2 = r.data_next;
                        remaining = 8'd0;
                    end else begin
                        if (remaining == 8'd3) a.ack = i2cms_pkg::ACK_CLR;
                        a.rxn = 2'd1;
                        a.rx1 = r.data;
                        if (remaining != 0) remaining = remaining - 8'd1;
                    end
                end
                default: begin
                    stop_sent = 1'b1;
                    bus_status = (r.cmd == i2cms_pkg::CMD_NACK) ?
                                 i2cms_pkg::ST_NACK : i2cms_pkg::ST_ERR;
                    a.stop = 1'b1;
                end
            endcase
        end else if (r.cmd == i2cms_pkg::CMD_BUS_IDLE && stop_sent) begin
            stop_sent = 1'b0;
            // A one-byte read hands over its byte only once the bus is idle.
            if (bus_status == i2cms_pkg::ST_ACK && ring_count[cur_slot] == 8'd1 &&
                !ring_wr[cur_slot]) begin
                a.rxn = 2'd1;
                a.rx1 = r.data;
            end
            a.done = 1'b1;
            a.dst = bus_status;
            a.dwr = ring_wr[cur_slot];
            bus_status = i2cms_pkg::ST_ACK;
            ring_ready[cur_slot] = 1'b0;
            cur_slot = cur_slot + 2'd1;
            busy = 1'b0;
            if (ring_ready[cur_slot]) a = launch_txn(a);
        end
        return a;
    endfunction

    function automatic bus_req_t rand_req(input logic [3:0] cmd);
        bus_req_t r;
        r.cmd = cmd;
        r.addr = 7'($urandom);
        r.count = 8'($urandom);
        r.data = 8'($urandom);
        r.data_next = 8'($urandom);
        return r;
    endfunction

    function automatic logic [7:0] pick_count();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 8'($urandom_range(0, 4));
        if (roll < 97) return 8'($urandom_range(5, 16));
        return 8'($urandom_range(17, 255));
    endfunction

    task automatic plan(input bus_req_t r);
        queued_t q;
        q.req = r;
        q.act = apply_item(r);
        q.drain = (pending.size() == DRAIN_AT);
        pending.push_back(q);
        if (q.act.start) bus_phase = PH_START;
    endtask

    task automatic plan_with(input logic [3:0] cmd, input logic [6:0] addr,
                             input logic [7:0] count, input logic [7:0] data);
        bus_req_t r;
        r = rand_req(cmd);
        r.addr = addr;
        r.count = count;
        r.data = data;
        plan(r);
    endtask

    task automatic check_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            failures++;
        end
    endtask

    // Driver: offers queued items, with random idle bursts and one pause for a full drain.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_actions.push_back(offered.act);
                items_sent++;
            end
            if (!s_valid || s_ready) begin
                if (send_idle > 0) begin
                    send_idle--;
                    s_valid <= 1'b0;
                end else if (pending.size() != 0 &&
                             !(pending[0].drain && expected_actions.size() != 0)) begin
                    if (pending.size() > TAIL_ITEMS && $urandom_range(0, 9) == 0) begin
                        send_idle = $urandom_range(0, 8);
                        s_valid <= 1'b0;
                    end else begin
                        offered = pending.pop_front();
                        s_valid <= 1'b1;
                        s_cmd <= offered.req.cmd;
                        s_slave_address <= offered.req.addr;
                        s_byte_count <= offered.req.count;
                        s_data_byte <= offered.req.data;
                        s_data_byte_next <= offered.req.data_next;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result and stalls the result channel at random, and once for a long stretch.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_actions.size() == 0) begin
                    $error("result arrived with no item outstanding");
                    failures++;
                end else begin
                    exp_a = expected_actions.pop_front();
                    check_field("accepted", exp_a.accepted, m_accepted);
                    check_field("drive_start", exp_a.start, m_drive_start);
                    check_field("drive_stop", exp_a.stop, m_drive_stop);
                    check_field("ack_control", exp_a.ack, m_ack_control);
                    check_field("tx_valid", exp_a.txv, m_tx_valid);
                    check_field("tx_byte", exp_a.txb, m_tx_byte);
                    check_field("rx_count", exp_a.rxn, m_rx_count);
                    check_field("rx_first", exp_a.rx1, m_rx_first);
                    check_field("rx_second", exp_a.rx2, m_rx_second);
                    check_field("done_res", exp_a.done, m_done_res);
                    check_field("done_status", exp_a.dst, m_done_status);
                    check_field("done_is_write", exp_a.dwr, m_done_is_write);
                end
            end
            if (recv_idle > 0) begin
                recv_idle--;
                m_ready <= 1'b0;
            end else if (!backlog_done && items_sent >= BACKLOG_AT) begin
                backlog_done = 1;
                recv_idle = BACKLOG_CYCLES - 1;
                m_ready <= 1'b0;
            end else if (pending.size() > TAIL_ITEMS && $urandom_range(0, 9) == 0) begin
                recv_idle = $urandom_range(0, 8);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        int roll;
        bus_req_t r;

        for (int i = 0; i < RING_SLOTS; i++) begin
            ring_ready[i] = 1'b0;
            ring_count[i] = '0;
            ring_addr[i] = '0;
            ring_wr[i] = 1'b0;
        end
        enq_slot = '0;
        cur_slot = '0;
        busy = 1'b0;
        stop_sent = 1'b0;
        bus_status = i2cms_pkg::ST_ACK;
        remaining = '0;
        fifo_wr = '0;
        fifo_rd = '0;
        send_idx = '0;
        bus_phase = PH_START;

        // Fill every FIFO slot first so that no write ever sends a slot that was never written.
        plan_with(i2cms_pkg::CMD_PUSH_TX, 7'd0, 8'd0, 8'h00);
        plan_with(i2cms_pkg::CMD_PUSH_TX, 7'd127, 8'd255, 8'hFF);
        for (int i = 2; i < FIFO_BYTES; i++)
            plan(rand_req(i2cms_pkg::CMD_PUSH_TX));
        plan_with(i2cms_pkg::CMD_PUSH_TX, 7'd0, 8'd0, 8'h5A);

        // Bus events with nothing running, and an unknown command.
        for (int c = i2cms_pkg::CMD_START_SENT; c <= i2cms_pkg::CMD_BUS_IDLE; c++)
            plan(rand_req(4'(c)));
        plan_with(4'hF, 7'd127, 8'd255, 8'hFF);

        // One-byte read, two-byte write, and a long read cut short by lost arbitration.
        plan_with(i2cms_pkg::CMD_ENQ_RD, 7'd127, 8'd1, 8'h00);
        plan(rand_req(i2cms_pkg::CMD_START_SENT));
        plan(rand_req(i2cms_pkg::CMD_ADDR_SENT));
        plan_with(i2cms_pkg::CMD_BUS_IDLE, 7'd0, 8'd0, 8'hC3);
        plan_with(i2cms_pkg::CMD_ENQ_WR, 7'd0, 8'd2, 8'h00);
        plan(rand_req(i2cms_pkg::CMD_START_SENT));
        plan(rand_req(i2cms_pkg::CMD_ADDR_SENT));
        plan(rand_req(i2cms_pkg::CMD_BYTE_DONE));
        plan(rand_req(i2cms_pkg::CMD_BYTE_DONE));
        plan(rand_req(i2cms_pkg::CMD_BUS_IDLE));
        plan_with(i2cms_pkg::CMD_ENQ_RD, 7'h55, 8'd255, 8'h00);
        plan(rand_req(i2cms_pkg::CMD_START_SENT));
        plan(rand_req(i2cms_pkg::CMD_ADDR_SENT));
        plan_with(i2cms_pkg::CMD_BYTE_DONE, 7'd0, 8'd0, 8'hFF);
        plan(rand_req(i2cms_pkg::CMD_ARB_LOST));
        plan(rand_req(i2cms_pkg::CMD_BUS_IDLE));

        // Mostly well-formed bus conversations, with pushes, extra enqueues and noise mixed in.
        while (pending.size() < ITEM_TOTAL) begin
            roll = $urandom_range(0, 99);
            if (roll < 4) begin
                plan(rand_req(4'($urandom_range(0, 15))));
            end else if (roll < 12) begin
                plan(rand_req(i2cms_pkg::CMD_PUSH_TX));
            end else if (roll < 18 || !busy) begin
                r = rand_req($urandom_range(0, 1) ? i2cms_pkg::CMD_ENQ_WR
                                                  : i2cms_pkg::CMD_ENQ_RD);
                r.count = pick_count();
                plan(r);
            end else if (stop_sent) begin
                plan(rand_req(roll < 25 ? i2cms_pkg::CMD_BYTE_DONE : i2cms_pkg::CMD_BUS_IDLE));
            end else if (roll < 22) begin
                plan(rand_req(4'($urandom_range(i2cms_pkg::CMD_NACK,
                                                i2cms_pkg::CMD_BUS_ERR))));
            end else begin
                case (bus_phase)
                    PH_START: begin
                        plan(rand_req(i2cms_pkg::CMD_START_SENT));
                        bus_phase = PH_ADDR;
                    end
                    PH_ADDR: begin
                        plan(rand_req(i2cms_pkg::CMD_ADDR_SENT));
                        bus_phase = PH_DATA;
                    end
                    default: begin
                        // A read of zero bytes only ends on an error.
                        if (!ring_wr[cur_slot] && remaining == 0 && $urandom_range(0, 2) == 0)
                            plan(rand_req(4'($urandom_range(i2cms_pkg::CMD_NACK,
                                                            i2cms_pkg::CMD_BUS_ERR))));
                        else
                            plan(rand_req(i2cms_pkg::CMD_BYTE_DONE));
                    end
                endcase
            end
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        while (items_sent < ITEM_TOTAL || expected_actions.size() != 0)
            @(posedge aclk);
        repeat (16) @(posedge aclk);

        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[filelist.f]
rtl/i2cms_pkg.sv
rtl/i2cms_ram.sv
rtl/i2cms_ring.sv
rtl/i2cms_txfifo.sv
rtl/i2c_master_transaction_sequencer.sv
sim/i2c_master_transaction_sequencer_test.sv
